@@ rtl/core/nearest_sample_rate_converter_macros.svh @@
// Assertion macros used by the checker file of the sample rate converter.
// Stand-alone header; the including module supplies clk and rst.
`ifndef NEAREST_SAMPLE_RATE_CONVERTER_MACROS_SVH
`define NEAREST_SAMPLE_RATE_CONVERTER_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define NSRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset
`define NSRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/nsrc_pkg.sv @@
// Package of the nearest sample rate converter: item types, register map,
// sequencer states and constants. No dependencies.
`timescale 1ns / 1ps

package nsrc_pkg;

  // Register reset values and limits
  localparam logic [11:0] StepReset      = 12'd256;
  localparam logic [1:0]  SampleWidth16  = 2'd2;
  localparam logic [23:0] CountReset     = 24'd0;
  localparam int          ChunkSizeDef   = 1024;
  localparam int          MaxPerInput    = 4;
  localparam int          AddrW          = 4;

  // Register index within the APB map (byte address / 4)
  typedef enum logic [1:0] {
    REG_STEP  = 2'd0,
    REG_WIDTH = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_t;

  // Shared adder operations
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_TEST    = 2'd1,
    ST_ADVANCE = 2'd2,
    ST_BUMP    = 2'd3
  } state_t;

  typedef struct packed {
    logic [11:0] step_fraction;
    logic [1:0]  sample_width;
    logic [23:0] output_count;
  } cfg_t;

  typedef struct packed {
    logic [15:0] raw_sample;
    logic        sound_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic [9:0]         chunk_offset;
    logic               chunk_begin;
    logic               run_last;
    logic               sound_done;
  } out_item_t;

endpackage

@@ rtl/core/nsrc_regs.sv @@
// APB configuration registers: step, sample width and output count.
// Depends on nsrc_pkg.
`timescale 1ns / 1ps

module nsrc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nsrc_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output nsrc_pkg::cfg_t               cfg
);
  import nsrc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_fraction <= StepReset;
      cfg.sample_width  <= SampleWidth16;
      cfg.output_count  <= CountReset;
    end else if (wr_en) begin
      case (idx)
        REG_STEP:  cfg.step_fraction <= pwdata[11:0];
        REG_WIDTH: cfg.sample_width  <= pwdata[1:0];
        REG_COUNT: cfg.output_count  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_STEP:  prdata = {20'd0, cfg.step_fraction};
      REG_WIDTH: prdata = {30'd0, cfg.sample_width};
      REG_COUNT: prdata = {8'd0, cfg.output_count};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/nsrc_alu.sv @@
// Shared 32-bit add/subtract unit, time-multiplexed by the sequencer.
// Depends on nsrc_pkg.
`timescale 1ns / 1ps

module nsrc_alu (
  input  nsrc_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       y
);
  import nsrc_pkg::*;

  // Subtract as add of the inverted operand plus one
  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a + ~b + 32'd1;
      default: y = a + b;
    endcase
  end

endmodule

@@ rtl/core/nsrc_seq.sv @@
// Sequencer and state of the converter: position test, output emission,
// position advance and source index update through the shared adder.
// Depends on nsrc_pkg and nsrc_alu.
`timescale 1ns / 1ps

module nsrc_seq #(
  parameter int CHUNK_SIZE = nsrc_pkg::ChunkSizeDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nsrc_pkg::cfg_t       cfg,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  nsrc_pkg::in_item_t   sample_item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output nsrc_pkg::out_item_t  result_item
);
  import nsrc_pkg::*;

  localparam int ChunkW = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;
  localparam int CntW   = $clog2(MaxPerInput + 1);

  state_t      state, state_next;
  alu_op_t     alu_op;
  logic [31:0] alu_a, alu_b, alu_y;

  // Sound state
  logic [23:0]       source_index;
  logic [31:0]       position_accum;
  logic [23:0]       outputs_done;
  logic [ChunkW-1:0] chunk_cnt;

  // Per-item working registers
  logic [15:0]     sample_conv;
  logic [CntW-1:0] n_cnt;
  out_item_t       pending;
  logic            have_pending;

  logic accept, slot_free, due, take, push;

  nsrc_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Output due: below per-item cap, sound not complete, position not ahead
  assign slot_free = !result_valid || result_ready;
  assign due       = (n_cnt < CntW'(MaxPerInput)) &&
                     (outputs_done < cfg.output_count) && !alu_y[23];
  assign accept    = sample_valid && sample_ready;
  assign take      = (state == ST_TEST) && due && (!have_pending || slot_free);
  assign push      = (state == ST_TEST) && have_pending && slot_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_TEST;
      end
      ST_TEST: begin
        if (!have_pending || slot_free) state_next = due ? ST_ADVANCE : ST_BUMP;
      end
      ST_ADVANCE: state_next = ST_TEST;
      ST_BUMP:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake and adder operand select
  always_comb begin
    sample_ready = 1'b0;
    alu_op       = ALU_ADD;
    alu_a        = 32'd0;
    alu_b        = 32'd0;
    case (state)
      ST_IDLE: sample_ready = 1'b1;
      ST_TEST: begin
        // modular distance source_index - integer position
        alu_op = ALU_SUB;
        alu_a  = {8'd0, source_index};
        alu_b  = {8'd0, position_accum[31:8]};
      end
      ST_ADVANCE: begin
        alu_a = position_accum;
        alu_b = {20'd0, cfg.step_fraction};
      end
      ST_BUMP: begin
        alu_a = {8'd0, source_index};
        alu_b = 32'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sound state and per-item control
  always_ff @(posedge clk) begin
    if (rst) begin
      source_index   <= 24'd0;
      position_accum <= 32'd0;
      outputs_done   <= 24'd0;
      chunk_cnt      <= '0;
      n_cnt          <= '0;
      have_pending   <= 1'b0;
    end else begin
      if (accept) begin
        n_cnt        <= '0;
        have_pending <= 1'b0;
        if (sample_item.sound_start) begin
          source_index   <= 24'd0;
          position_accum <= 32'd0;
          outputs_done   <= 24'd0;
          chunk_cnt      <= '0;
        end
      end
      if (take) begin
        have_pending <= 1'b1;
        outputs_done <= outputs_done + 24'd1;
        n_cnt        <= n_cnt + CntW'(1);
        if (chunk_cnt == ChunkW'(CHUNK_SIZE - 1)) chunk_cnt <= '0;
        else                                      chunk_cnt <= chunk_cnt + ChunkW'(1);
      end else if (push) begin
        have_pending <= 1'b0;
      end
      if (state == ST_ADVANCE) position_accum <= alu_y;
      if (state == ST_BUMP)    source_index   <= alu_y[23:0];
    end
  end

  // Sample conversion and pending result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cfg.sample_width == SampleWidth16) sample_conv <= sample_item.raw_sample;
      else sample_conv <= {~sample_item.raw_sample[7], sample_item.raw_sample[6:0], 8'h00};
    end
    if (take) begin
      pending.out_sample   <= sample_conv;
      pending.chunk_offset <= 10'(chunk_cnt);
      pending.chunk_begin  <= (chunk_cnt == '0);
      pending.run_last     <= 1'b0;
      pending.sound_done   <= ((outputs_done + 24'd1) == cfg.output_count);
    end
  end

  // Output register; the run ends when no further output is due
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result_item <= {pending.out_sample, pending.chunk_offset, pending.chunk_begin,
                      !due, pending.sound_done};
    end
  end

endmodule

@@ rtl/core/nearest_sample_rate_converter.sv @@
// Nearest-neighbor sample rate converter top level: APB registers and sequencer.
// Per item: accept in idle, then per result a position test and a shared-adder
// position advance, then a final position test and the source index update; a
// stalled result register holds the sequencer in the position test. New items
// are taken only in idle; the first result is registered at the second test.
// Reset (rst, synchronous): registers to defaults, position and counters to zero.
`timescale 1ns / 1ps

module nearest_sample_rate_converter #(
  parameter int CHUNK_SIZE = nsrc_pkg::ChunkSizeDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nsrc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  nsrc_pkg::in_item_t          sample_item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output nsrc_pkg::out_item_t         result_item
);
  import nsrc_pkg::*;

  cfg_t cfg;

  nsrc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nsrc_seq #(
    .CHUNK_SIZE (CHUNK_SIZE)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

@@ rtl/core/nsrc_checker.sv @@
// Port-level checker of the converter, bound to the top level.
// Depends on nsrc_pkg and nearest_sample_rate_converter_macros.svh.
`timescale 1ns / 1ps
`include "nearest_sample_rate_converter_macros.svh"

module nsrc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 sample_valid,
  input logic                 sample_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input nsrc_pkg::out_item_t  result_item
);
  import nsrc_pkg::*;

  logic out_stall, in_fire, out_done, out_begin, out_at_zero;

  assign out_stall   = result_valid && !result_ready;
  assign in_fire     = sample_valid && sample_ready;
  assign out_done    = result_valid && result_item.sound_done;
  assign out_begin   = result_valid && result_item.chunk_begin;
  assign out_at_zero = (result_item.chunk_offset == 10'd0);

  // A stalled result transfer holds its payload
  `NSRC_ASSERT_NEXT(a_hold, out_stall, result_valid && $stable(result_item), "held result changed")

  // One item at a time: not ready right after an input transfer
  `NSRC_ASSERT_NEXT(a_busy, in_fire, !sample_ready, "ready right after input transfer")

  // The final output of a sound always closes its run
  `NSRC_ASSERT_NOW(a_done_is_last, out_done, result_item.run_last, "sound_done without run_last")

  // A chunk opens only at offset zero
  `NSRC_ASSERT_NOW(a_chunk_begin, out_begin, out_at_zero, "chunk_begin at nonzero offset")

endmodule

bind nearest_sample_rate_converter nsrc_checker u_nsrc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_item  (result_item)
);

@@ bench/nearest_sample_rate_converter_tb.sv @@
// Self-checking bench for the nearest-neighbor sample rate converter.
// Depends on nsrc_pkg and the nearest_sample_rate_converter RTL.
`timescale 1ns / 1ps

module nearest_sample_rate_converter_tb;
  import nsrc_pkg::*;

  localparam int ChunkSize    = ChunkSizeDef;
  localparam int IdlePct      = 29;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 20;
  localparam int StallLimit   = 2000;

  // Sample width codes other than the signed 16-bit one
  localparam logic [1:0] WidthU8      = 2'd1;
  localparam logic [1:0] WidthOddLow  = 2'd0;
  localparam logic [1:0] WidthOddHigh = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  in_item_t    sample_item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result_item;

  // Source samples waiting to be offered, and outputs the predictor still owes
  in_item_t  source_q[$];
  out_item_t due_outputs[$];

  // Register shadow and resampler state of the predictor
  logic [11:0] step_cfg  = StepReset;
  logic [1:0]  width_cfg = SampleWidth16;
  logic [23:0] count_cfg = CountReset;
  logic [23:0] src_index = '0;
  logic [31:0] position  = '0;
  logic [23:0] emitted   = '0;

  logic sample_fired = 1'b0;
  int   src_idle_pct = IdlePct;
  int   sink_idle_pct = IdlePct;
  int   hold_requests = 0;
  int   hold_taken = 0;
  int   hold_left = 0;
  int   error_count = 0;
  int   stall_cycles = 0;

  nearest_sample_rate_converter #(
    .CHUNK_SIZE(ChunkSize)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  always #1 clk = ~clk;

  // Expected outputs for one accepted source sample
  task automatic resample(input in_item_t item);
    logic [15:0] pcm;
    logic [23:0] lag;
    out_item_t   burst[MaxPerInput];
    int          n;
    if (item.sound_start) begin
      src_index = '0;
      position  = '0;
      emitted   = '0;
    end
    if (width_cfg == SampleWidth16) begin
      pcm = item.raw_sample;
    end else begin
      pcm = {item.raw_sample[7:0] ^ 8'h80, 8'h00};
    end
    n = 0;
    lag = src_index - position[31:8];
    // modular "not ahead" test: top bit of the lag clear
    while (n < MaxPerInput && emitted < count_cfg && !lag[23]) begin
      burst[n].out_sample   = pcm;
      burst[n].chunk_offset = 10'(emitted % ChunkSize);
      burst[n].chunk_begin  = ((emitted % ChunkSize) == 0);
      burst[n].run_last     = 1'b0;
      burst[n].sound_done   = ((emitted + 24'd1) == count_cfg);
      emitted  = emitted + 24'd1;
      position = position + step_cfg;
      n++;
      lag = src_index - position[31:8];
    end
    if (n > 0) burst[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) due_outputs.push_back(burst[k]);
    src_index = src_index + 24'd1;
  endtask

  // Register write: setup phase, then access phase until pready
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [11:0] step, input logic [1:0] width,
                           input logic [23:0] count);
    apb_write(REG_STEP, 32'(step));
    apb_write(REG_WIDTH, 32'(width));
    apb_write(REG_COUNT, 32'(count));
  endtask

  task automatic queue_sample(input logic [15:0] raw, input logic start);
    in_item_t item;
    item.raw_sample  = raw;
    item.sound_start = start;
    source_q.push_back(item);
  endtask

  // Wait until every sample went in and every output came out, then let
  // the sequencer finish any sample that gives no output
  task automatic settle();
    while (source_q.size() != 0 || sample_valid || due_outputs.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Sample driver: holds each transfer until accepted
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_fired) begin
      if (source_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        sample_item  <= source_q.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result sink: random backpressure plus requested long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_taken != hold_requests) begin
      hold_taken   <= hold_requests;
      hold_left    <= HoldCycles;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: register writes, sample transfers, result checks
  always @(posedge clk) begin
    sample_fired <= sample_valid && sample_ready && !rst;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_STEP:  step_cfg  = pwdata[11:0];
          REG_WIDTH: width_cfg = pwdata[1:0];
          REG_COUNT: count_cfg = pwdata[23:0];
          default: ;
        endcase
      end
      if (sample_valid && sample_ready) resample(sample_item);
      if (result_valid && result_ready) begin
        if (due_outputs.size() == 0) begin
          if (error_count < 10)
            $display("unexpected output: sample %0d offset %0d begin %b last %b done %b",
                     result_item.out_sample, result_item.chunk_offset,
                     result_item.chunk_begin, result_item.run_last, result_item.sound_done);
          error_count++;
        end else begin
          out_item_t want;
          want = due_outputs.pop_front();
          if (result_item.out_sample !== want.out_sample ||
              result_item.chunk_offset !== want.chunk_offset ||
              result_item.chunk_begin !== want.chunk_begin ||
              result_item.run_last !== want.run_last ||
              result_item.sound_done !== want.sound_done) begin
            if (error_count < 10)
              $display("mismatch: expected %0d/%0d/%b/%b/%b got %0d/%0d/%b/%b/%b %s",
                       want.out_sample, want.chunk_offset, want.chunk_begin,
                       want.run_last, want.sound_done,
                       result_item.out_sample, result_item.chunk_offset,
                       result_item.chunk_begin, result_item.run_last,
                       result_item.sound_done, "(sample/offset/begin/last/done)");
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("** nearest_sample_rate_converter: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [11:0] step;
    logic [23:0] count;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: output count zero, so the sound is already complete
    queue_sample(16'h1234, 1'b1);
    queue_sample(16'hFFFF, 1'b0);
    settle();

    // One output per sample, signed 16-bit extremes
    apb_write(REG_COUNT, 32'd12);
    queue_sample(16'h8000, 1'b1);
    queue_sample(16'h7FFF, 1'b0);
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'h0001, 1'b0);
    settle();

    // Minimum step, 8-bit: four outputs per sample, then the sound ends
    configure(12'd64, WidthU8, 24'd10);
    queue_sample(16'hAB00, 1'b1);
    queue_sample(16'h00FF, 1'b0);
    queue_sample(16'h0080, 1'b0);
    queue_sample(16'hFF7F, 1'b0);
    settle();

    // Maximum step and count, width code zero acts as 8-bit
    configure(12'd4095, WidthOddLow, 24'hFFFFFF);
    queue_sample(16'h55AA, 1'b1);
    queue_sample(16'hAA55, 1'b0);
    queue_sample(16'h0000, 1'b0);
    settle();

    // Zero step with width code three: four per sample until the count
    configure(12'd0, WidthOddHigh, 24'd9);
    queue_sample(16'hFF00, 1'b1);
    queue_sample(16'h00FF, 1'b0);
    queue_sample(16'h1280, 1'b0);
    settle();

    // Step below range: due outputs pile up and drain four at a time
    configure(12'd16, SampleWidth16, 24'd40);
    queue_sample(16'h4000, 1'b1);
    queue_sample(16'hC000, 1'b0);
    queue_sample(16'h2222, 1'b0);
    queue_sample(16'hDDDD, 1'b0);
    queue_sample(16'h0F0F, 1'b0);
    settle();

    // Count lowered below the outputs so far, then raised again mid-sound
    apb_write(REG_COUNT, 32'd5);
    queue_sample(16'h1111, 1'b0);
    settle();
    apb_write(REG_COUNT, 32'd24);
    queue_sample(16'h9999, 1'b0);
    settle();

    // Random sounds under random settings
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(4))
        0: step = 12'd64;
        1: step = 12'd4095;
        2: step = 12'($urandom_range(4095, 64));
        3: step = 12'($urandom_range(512, 64));
        default: step = 12'($urandom_range(63));
      endcase
      count = ($urandom_range(5) == 0) ? 24'hFFFFFF : 24'($urandom_range(150, 20));
      if (phase == 1) begin
        step  = 12'd64;
        count = 24'hFFFFFF;
      end
      configure(step, 2'($urandom_range(3)), count);
      src_idle_pct  = (phase == 3) ? 0 : IdlePct;
      sink_idle_pct = (phase == 3) ? 0 : IdlePct;
      for (int n = 0; n < 26; n++) begin
        if (n == 0)
          queue_sample(16'($urandom), $urandom_range(9) != 0);
        else
          queue_sample(16'($urandom), $urandom_range(19) == 0);
        // sender stops until the block has drained
        if (phase == 4 && n == 14) settle();
      end
      // receiver holds off so the block backs up into its input
      if (phase == 1) hold_requests++;
      settle();
    end

    if (error_count == 0) begin
      $display("** nearest_sample_rate_converter: PASSED **");
    end else begin
      $display("** nearest_sample_rate_converter: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/nsrc_pkg.sv
rtl/core/nsrc_regs.sv
rtl/core/nsrc_alu.sv
rtl/core/nsrc_seq.sv
rtl/core/nearest_sample_rate_converter.sv
rtl/core/nsrc_checker.sv
bench/nearest_sample_rate_converter_tb.sv
